/* sv/bucket_hash_table_top_defines.svh */
// Assertion macros for the bucket hash table top level.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef BUCKET_HASH_TABLE_TOP_DEFINES_SVH
`define BUCKET_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bucket hash table check failed");

// Next-cycle implication, disabled during reset
`define BHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bucket hash table check failed");

`endif

/* sv/bht_pkg.sv */
// Shared types and constants of the bucket hash table.
// No dependencies; imported by the datapath, the controller and the top level.
`timescale 1ns / 1ps

package bht_pkg;

    // Default sizes
    localparam int NUM_BUCKETS_DEF      = 30;
    localparam int SLOTS_PER_BUCKET_DEF = 5;
    localparam int INDEX_DEPTH_DEF      = 150;
    localparam int PAYLOAD_BITS_DEF     = 64;

    // Fixed field widths
    localparam int KEY_W = 31;

    // Operation codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_DUPLICATE   = 3'd1,
        ST_INDEX_FULL  = 3'd2,
        ST_BUCKET_FULL = 3'd3,
        ST_FOUND       = 3'd4,
        ST_NOT_FOUND   = 3'd5
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  record_key;
        logic [63:0]       payload;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [4:0]  bucket;
        logic [2:0]  slot;
        logic [63:0] found_payload;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    hash_step;
        logic    scan_init;
        logic    scan_step;
        logic    ins_commit;
        logic    pay_read;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic kind;
        logic hash_last;
        logic scan_done;
        logic match;
        logic index_full;
        logic bucket_full;
    } t_dp_stat;

endpackage

/* sv/bht_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled; the read is always registered, and gives the old word during a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bht_datapath.sv */
// Datapath of the bucket hash table: hash unit, index scan, stores, result register.
// Depends on bht_pkg and bht_ram.
`timescale 1ns / 1ps

module bht_datapath
    import bht_pkg::*;
#(
    parameter int NUM_BUCKETS      = NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
    parameter int INDEX_DEPTH      = INDEX_DEPTH_DEF,
    parameter int PAYLOAD_BITS     = PAYLOAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int SLOT_W      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int SLOT_CW     = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int IDX_AW      = $clog2(INDEX_DEPTH);
    localparam int IDX_CW      = $clog2(INDEX_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IDX_W       = KEY_W + BKT_W + SLOT_W;

    // Reciprocal of the bucket count, rounded up, exact for every key
    localparam int          HASH_SH = KEY_W + BKT_W;
    localparam logic [63:0] HASH_M  = ((64'd1 << HASH_SH) + 64'(NUM_BUCKETS) - 64'd1)
                                      / 64'(NUM_BUCKETS);
    localparam int          PROD_W  = KEY_W + 32;

    // Item registers
    logic                    r_kind;
    logic [KEY_W-1:0]        r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // Hash unit
    logic [BKT_W-1:0]  r_rem;
    logic              r_hphase;
    logic [PROD_W-1:0] r_prod;
    logic [KEY_W-1:0]  hash_q;

    // Scan state
    logic [STORE_AW-1:0] r_base;
    logic [IDX_CW-1:0]   r_index_count;
    logic [IDX_CW-1:0]   r_rd_addr;
    logic                r_chk;
    logic                r_match;
    logic [SLOT_W-1:0]   r_match_slot;
    logic [SLOT_CW-1:0]  r_bcount;

    // Result register
    logic      r_done;
    t_out_item r_result;

    // Memory ports
    logic [IDX_AW-1:0]       idx_addr;
    logic [IDX_W-1:0]        idx_wdata;
    logic [IDX_W-1:0]        idx_rdata;
    logic [KEY_W-1:0]        rd_key;
    logic [BKT_W-1:0]        rd_bucket;
    logic [SLOT_W-1:0]       rd_slot;
    logic [STORE_AW-1:0]     pay_addr;
    logic [PAYLOAD_BITS-1:0] pay_rdata;
    logic                    hit_now;
    logic                    can_issue;

    assign rd_key    = idx_rdata[IDX_W-1 -: KEY_W];
    assign rd_bucket = idx_rdata[SLOT_W +: BKT_W];
    assign rd_slot   = idx_rdata[SLOT_W-1:0];
    assign hit_now   = r_chk && !r_match && (rd_key == r_key);
    assign can_issue = !r_match && (r_rd_addr != r_index_count);

    // Quotient of key by bucket count from the registered product
    assign hash_q = KEY_W'(r_prod >> HASH_SH);

    // Index write goes to the first free entry, reads follow the scan pointer
    assign idx_addr  = i_cmd.ins_commit ? r_index_count[IDX_AW-1:0] : r_rd_addr[IDX_AW-1:0];
    assign idx_wdata = {r_key, r_rem, SLOT_W'(r_bcount)};
    assign pay_addr  = i_cmd.pay_read ? STORE_AW'(r_base + STORE_AW'(r_match_slot))
                                      : STORE_AW'(r_base + STORE_AW'(r_bcount));

    bht_ram #(
        .WIDTH (IDX_W),
        .DEPTH (INDEX_DEPTH)
    ) u_index_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_commit),
        .i_addr  (idx_addr),
        .i_wdata (idx_wdata),
        .o_rdata (idx_rdata)
    );

    bht_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_commit),
        .i_addr  (pay_addr),
        .i_wdata (r_payload),
        .o_rdata (pay_rdata)
    );

    // Capture the item, then multiply by the reciprocal and take the remainder; scan_init sets the bucket base
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_item.kind;
            r_key     <= i_item.record_key;
            r_payload <= i_item.payload[PAYLOAD_BITS-1:0];
            r_hphase  <= 1'b0;
        end else if (i_cmd.hash_step) begin
            if (!r_hphase) begin
                r_prod   <= PROD_W'(r_key) * PROD_W'(HASH_M[31:0]);
                r_hphase <= 1'b1;
            end else begin
                r_rem <= BKT_W'(r_key - KEY_W'(hash_q * KEY_W'(NUM_BUCKETS)));
            end
        end
        if (i_cmd.scan_init) begin
            r_base <= STORE_AW'(r_rem * SLOTS_PER_BUCKET);
        end
    end

    // Index scan: issue one read a cycle, compare the entry read the cycle before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_count <= '0;
            r_chk         <= 1'b0;
            r_match       <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_rd_addr <= '0;
                r_chk     <= 1'b0;
                r_match   <= 1'b0;
                r_bcount  <= '0;
            end else if (i_cmd.scan_step) begin
                if (can_issue && !hit_now) begin
                    r_rd_addr <= r_rd_addr + IDX_CW'(1);
                    r_chk     <= 1'b1;
                end else begin
                    r_chk     <= 1'b0;
                end
                if (hit_now) begin
                    r_match      <= 1'b1;
                    r_match_slot <= rd_slot;
                end else if (r_chk && !r_match && (rd_bucket == r_rem)) begin
                    r_bcount <= r_bcount + SLOT_CW'(1);
                end
            end
            if (i_cmd.ins_commit) begin
                r_index_count <= r_index_count + IDX_CW'(1);
            end
        end
    end

    // Result register, shown for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.res_load;
        end
        if (i_cmd.res_load) begin
            r_result.status <= i_cmd.res_status;
            r_result.bucket <= 5'(r_rem);
            case (i_cmd.res_status)
                ST_INSERTED: begin
                    r_result.slot          <= 3'(r_bcount);
                    r_result.found_payload <= '0;
                end
                ST_FOUND: begin
                    r_result.slot          <= 3'(r_match_slot);
                    r_result.found_payload <= 64'(pay_rdata);
                end
                default: begin
                    r_result.slot          <= 3'd0;
                    r_result.found_payload <= '0;
                end
            endcase
        end
    end

    assign o_stat.kind        = r_kind;
    assign o_stat.hash_last   = r_hphase;
    assign o_stat.scan_done   = r_match || (!r_chk && (r_rd_addr == r_index_count));
    assign o_stat.match       = r_match;
    assign o_stat.index_full  = (r_index_count == IDX_CW'(INDEX_DEPTH));
    assign o_stat.bucket_full = (r_bcount == SLOT_CW'(SLOTS_PER_BUCKET));
    assign o_done             = r_done;
    assign o_result           = r_result;

endmodule

/* sv/bht_ctrl.sv */
// Sequencing controller of the bucket hash table.
// Depends on bht_pkg; drives the datapath by command and status structs.
`timescale 1ns / 1ps

module bht_ctrl
    import bht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_BASE,
        S_SCAN,
        S_DECIDE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                if (i_stat.kind == KIND_SEARCH) begin
                    if (i_stat.match) begin
                        o_cmd.pay_read = 1'b1;
                        n_state        = S_READ;
                    end else begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                    end
                end else begin
                    o_cmd.res_load = 1'b1;
                    if (i_stat.match) begin
                        o_cmd.res_status = ST_DUPLICATE;
                    end else if (i_stat.index_full) begin
                        o_cmd.res_status = ST_INDEX_FULL;
                    end else if (i_stat.bucket_full) begin
                        o_cmd.res_status = ST_BUCKET_FULL;
                    end else begin
                        o_cmd.ins_commit = 1'b1;
                        o_cmd.res_status = ST_INSERTED;
                    end
                end
            end
            S_READ: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_FOUND;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // Hold state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

/* sv/bucket_hash_table_top.sv */
// Channel   Ports                      Handshake
// item in   start, busy, i_item        taken at a clock edge with start high, busy low
// result    o_done, o_result           o_done high for one cycle, always taken
//
// Busy covers the key modulo bucket count by reciprocal multiply, the bucket base, the
// pipelined index reads and compares (all filled entries, or up to a match), the decision
// and, for a search hit, one payload read. The result shows in the cycle that busy drops
// and the next item may start while it shows; the receiver cannot stall.
// Synchronous reset empties both stores at once through the index fill count.
// Depends on bht_pkg, bht_ctrl, bht_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "bucket_hash_table_top_defines.svh"

module bucket_hash_table_top
    import bht_pkg::*;
#(
    parameter int NUM_BUCKETS      = NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
    parameter int INDEX_DEPTH      = INDEX_DEPTH_DEF,
    parameter int PAYLOAD_BITS     = PAYLOAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bht_datapath #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .INDEX_DEPTH      (INDEX_DEPTH),
        .PAYLOAD_BITS     (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // An accepted item keeps the block busy
    `BHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // A result follows work in progress
    `BHT_ASSERT_NOW(a_done_after_busy, o_done, $past(busy))
    // Only a search hit carries payload
    `BHT_ASSERT_NOW(a_payload_zero, o_done && (o_result.status != ST_FOUND), o_result.found_payload == 64'd0)
    // Slot is zero unless written or found
    `BHT_ASSERT_NOW(a_slot_zero, o_done && (o_result.status != ST_FOUND) && (o_result.status != ST_INSERTED), o_result.slot == 3'd0)

endmodule
